>>> rtl/sbt_pkg.sv
// Shared types, constants and helpers for the source byte tokenizer.
// No dependencies; every other file of the block imports this package.
package sbt_pkg;

  localparam int BYTE_W  = 8;
  localparam int LINE_W  = 24;
  localparam int VALUE_W = 31;

  localparam int SBT_QUEUE_DEPTH = 4;

  localparam logic [LINE_W-1:0]  START_LINE_RESET = 24'd1;
  localparam logic [VALUE_W-1:0] VALUE_MAX        = 31'h7FFF_FFFF;

  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [BYTE_W-1:0] CH_EQUALS  = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;

  typedef enum logic [3:0] {
    KIND_EOF    = 4'd0,
    KIND_PLUS   = 4'd1,
    KIND_LPAREN = 4'd2,
    KIND_RPAREN = 4'd3,
    KIND_SEMI   = 4'd4,
    KIND_EQUALS = 4'd5,
    KIND_STRING = 4'd6,
    KIND_IDENT  = 4'd7,
    KIND_NUMBER = 4'd8,
    KIND_ERROR  = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_STRING = 3'd1,
    MODE_IDENT  = 3'd2,
    MODE_NUMBER = 3'd3,
    MODE_HALTED = 3'd4
  } mode_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  text_byte;
    logic               text_valid;
    logic [VALUE_W-1:0] number_value;
    logic [LINE_W-1:0]  line_number;
    logic               token_done;
  } result_t;

  // One queue entry: everything a single source byte produces.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

  function automatic result_t make_result(kind_t kind, logic [BYTE_W-1:0] text_byte,
                                          logic text_valid, logic [VALUE_W-1:0] value,
                                          logic [LINE_W-1:0] line, logic done);
    result_t r;
    r.kind         = kind;
    r.text_byte    = text_byte;
    r.text_valid   = text_valid;
    r.number_value = value;
    r.line_number  = line;
    r.token_done   = done;
    return r;
  endfunction

endpackage

>>> rtl/sbt_ifs.sv
// Channel interfaces of the source byte tokenizer: source bytes in, tokens out.
// Depends on sbt_pkg for field widths.
interface sbt_in_if import sbt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] input_byte;
  logic              end_of_source;

  modport source (output valid, output input_byte, output end_of_source, input ready);
  modport sink   (input valid, input input_byte, input end_of_source, output ready);
endinterface

interface sbt_out_if import sbt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic [BYTE_W-1:0]  text_byte;
  logic               text_valid;
  logic [VALUE_W-1:0] number_value;
  logic [LINE_W-1:0]  line_number;
  logic               token_done;
  logic               last;

  modport source (output valid, output token_kind, output text_byte, output text_valid,
                  output number_value, output line_number, output token_done,
                  output last, input ready);
  modport sink   (input valid, input token_kind, input text_byte, input text_valid,
                  input number_value, input line_number, input token_done,
                  input last, output ready);
endinterface

>>> rtl/sbt_front.sv
// Scanner front end: accepts source bytes, tracks scan mode and line count,
// and pushes the one or two results of a byte, if any, as one queue entry. Uses sbt_pkg.
module sbt_front import sbt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [LINE_W-1:0] cfg_data,
  sbt_in_if.sink            src,
  input  logic              full,
  output logic              push,
  output entry_t            entry
);

  mode_t              mode, mode_next;
  logic [LINE_W-1:0]  start_line;
  logic [LINE_W-1:0]  line_count, line_count_next;
  logic [LINE_W-1:0]  token_line, token_line_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               digits_ended, digits_ended_next;

  logic [BYTE_W-1:0]  c;
  logic               accept, eos;
  logic               is_space, is_newline, is_alpha, is_digit, is_quote, is_punct, is_delim;
  kind_t              punct_kind;
  logic               pending_active;
  result_t            pending_res, idle_res, eof_res;
  logic [VALUE_W+3:0] acc_x10;
  logic [VALUE_W-1:0] acc_sat;

  assign src.ready = !full;
  assign accept    = src.valid && src.ready;
  assign c         = src.input_byte;
  assign eos       = src.end_of_source;

  assign is_newline = (c == CH_NEWLINE);
  assign is_space   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_alpha   = ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
                      ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_quote   = (c == CH_QUOTE);
  assign is_delim   = is_space || (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN);

  always_comb begin
    is_punct   = 1'b1;
    punct_kind = KIND_PLUS;
    case (c)
      CH_PLUS:   punct_kind = KIND_PLUS;
      CH_LPAREN: punct_kind = KIND_LPAREN;
      CH_RPAREN: punct_kind = KIND_RPAREN;
      CH_SEMI:   punct_kind = KIND_SEMI;
      CH_EQUALS: punct_kind = KIND_EQUALS;
      default:   is_punct = 1'b0;
    endcase
  end

  // decimal step, saturating
  assign acc_x10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, c[3:0]};
  assign acc_sat = (acc_x10 > {4'b0, VALUE_MAX}) ? VALUE_MAX : acc_x10[VALUE_W-1:0];

  // completing result of an open token
  always_comb begin
    pending_active = 1'b1;
    pending_res    = make_result(KIND_STRING, '0, 1'b0, '0, token_line, 1'b1);
    case (mode)
      MODE_STRING: pending_res = make_result(KIND_STRING, '0, 1'b0, '0, token_line, 1'b1);
      MODE_IDENT:  pending_res = make_result(KIND_IDENT, '0, 1'b0, '0, token_line, 1'b1);
      MODE_NUMBER: pending_res = make_result(KIND_NUMBER, '0, 1'b0, acc, token_line, 1'b1);
      default:     pending_active = 1'b0;
    endcase
  end

  // result of a byte seen outside any token (unused for space and quote)
  always_comb begin
    if (is_punct) begin
      idle_res = make_result(punct_kind, '0, 1'b0, '0, line_count, 1'b1);
    end else if (is_alpha) begin
      idle_res = make_result(KIND_IDENT, c, 1'b1, '0, line_count, 1'b0);
    end else if (is_digit) begin
      idle_res = make_result(KIND_NUMBER, c, 1'b1, '0, line_count, 1'b0);
    end else begin
      idle_res = make_result(KIND_ERROR, c, 1'b1, '0, line_count, 1'b1);
    end
  end

  assign eof_res = make_result(KIND_EOF, '0, 1'b0, '0, line_count, 1'b1);

  // next mode
  always_comb begin
    mode_next = mode;
    if (accept && (mode != MODE_HALTED)) begin
      if (eos) begin
        mode_next = MODE_IDLE;
      end else begin
        case (mode)
          MODE_STRING: if (is_quote) mode_next = MODE_IDLE;
          MODE_IDENT:  if (is_delim) mode_next = MODE_IDLE;
          MODE_NUMBER: if (is_delim) mode_next = MODE_IDLE;
          default: begin
            if (is_space || is_punct) mode_next = MODE_IDLE;
            else if (is_quote)        mode_next = MODE_STRING;
            else if (is_alpha)        mode_next = MODE_IDENT;
            else if (is_digit)        mode_next = MODE_NUMBER;
            else                      mode_next = MODE_HALTED;
          end
        endcase
      end
    end
  end

  // results and datapath
  always_comb begin
    push              = 1'b0;
    entry             = '0;
    line_count_next   = line_count;
    token_line_next   = token_line;
    acc_next          = acc;
    digits_ended_next = digits_ended;
    if (accept && (mode != MODE_HALTED)) begin
      if (eos) begin
        push            = 1'b1;
        line_count_next = start_line;
        if (pending_active) begin
          entry.two    = 1'b1;
          entry.first  = pending_res;
          entry.second = eof_res;
        end else begin
          entry.first = eof_res;
        end
      end else begin
        case (mode)
          MODE_STRING: begin
            push        = 1'b1;
            entry.first = is_quote ? pending_res
                                   : make_result(KIND_STRING, c, 1'b1, '0, token_line, 1'b0);
          end
          MODE_IDENT, MODE_NUMBER: begin
            push = 1'b1;
            if (is_delim) begin
              entry.first = pending_res;
              if (is_punct) begin
                entry.two    = 1'b1;
                entry.second = idle_res;
              end
              if (is_newline) line_count_next = line_count + 1'b1;
            end else begin
              entry.first = make_result((mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
                                        c, 1'b1, '0, token_line, 1'b0);
              if (mode == MODE_NUMBER) begin
                if (!digits_ended && is_digit) acc_next = acc_sat;
                else                           digits_ended_next = 1'b1;
              end
            end
          end
          default: begin
            if (is_space) begin
              if (is_newline) line_count_next = line_count + 1'b1;
            end else if (is_quote) begin
              token_line_next = line_count;
            end else begin
              push        = 1'b1;
              entry.first = idle_res;
              if (is_alpha) token_line_next = line_count;
              if (is_digit) begin
                token_line_next   = line_count;
                acc_next          = {27'b0, c[3:0]};
                digits_ended_next = 1'b0;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      start_line   <= START_LINE_RESET;
      line_count   <= START_LINE_RESET;
      token_line   <= '0;
      acc          <= '0;
      digits_ended <= 1'b0;
    end else begin
      mode         <= mode_next;
      token_line   <= token_line_next;
      acc          <= acc_next;
      digits_ended <= digits_ended_next;
      if (cfg_write) begin
        start_line <= cfg_data;
        line_count <= cfg_data;
      end else begin
        line_count <= line_count_next;
      end
    end
  end

  // once halted, nothing more is produced
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_HALTED) |-> !push)
    else $error("push while halted");

  // two results only come from a token completion
  a_two_completes: assert property (@(posedge clk) disable iff (rst)
    (push && entry.two) |-> (entry.first.token_done && pending_active))
    else $error("double entry without completion");

endmodule

>>> rtl/sbt_queue.sv
// Short entry queue between scanner and output serializer.
// Uses sbt_pkg for the entry type.
module sbt_queue import sbt_pkg::*; #(
  parameter int DEPTH = SBT_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

>>> rtl/sbt_back.sv
// Output serializer: presents the head queue entry one result at a time
// and marks the last one. Uses sbt_pkg and the token channel interface.
module sbt_back import sbt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  entry_t head,
  input  logic   empty,
  output logic   pop,
  sbt_out_if.source tokens
);

  logic    phase;
  logic    fire, is_last;
  result_t sel;

  assign sel     = phase ? head.second : head.first;
  assign is_last = !head.two || phase;
  assign fire    = tokens.valid && tokens.ready;
  assign pop     = fire && is_last;

  assign tokens.valid        = !empty;
  assign tokens.token_kind   = sel.kind;
  assign tokens.text_byte    = sel.text_byte;
  assign tokens.text_valid   = sel.text_valid;
  assign tokens.number_value = sel.number_value;
  assign tokens.line_number  = sel.line_number;
  assign tokens.token_done   = sel.token_done;
  assign tokens.last         = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (fire) begin
      phase <= !is_last;
    end
  end

  a_phase_has_second: assert property (@(posedge clk) disable iff (rst)
    phase |-> (!empty && head.two))
    else $error("second slot selected without a pending double entry");

  a_first_then_second: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_last) |=> (phase && tokens.valid))
    else $error("second result lost after the first");

endmodule

>>> rtl/source_byte_tokenizer.sv
// Source byte tokenizer, top level: scanner front, entry queue, output serializer.
// A byte's results are written into the entry queue and offered from its head.
// Throughput: one byte per cycle while the queue is not full; a byte with two
//   results holds the port for both; output rate is one result per cycle when ready.
// Reset (rst, synchronous): queue emptied, scan mode idle, start_line = 1.
// Depends on sbt_pkg, sbt_ifs, sbt_front, sbt_queue, sbt_back.
module source_byte_tokenizer import sbt_pkg::*; #(
  parameter int QUEUE_DEPTH = SBT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [LINE_W-1:0] cfg_data,
  sbt_in_if.sink            src,
  sbt_out_if.source         tokens
);

  // Front end decodes each byte against the scan mode and pushes one entry
  // holding one or two results; whitespace and an opening quote push nothing.
  // src.ready drops only while the queue is full.
  logic   push, pop, full, empty;
  entry_t push_entry, head;

  sbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .src       (src),
    .full      (full),
    .push      (push),
    .entry     (push_entry)
  );

  // Queue decouples the scanner from output backpressure; its registers
  // also serve as the output register.
  sbt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  // Back end streams the head entry out and pops it after its last result.
  sbt_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .tokens (tokens)
  );

endmodule

>>> bench/sbt_token_checker.sv
// Scoreboard for the source byte tokenizer: predicts token results from the accepted
// source requests and start_line writes, and compares them with the token channel.
// Depends on sbt_pkg and the channel interfaces in sbt_ifs.
module sbt_token_checker import sbt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [LINE_W-1:0] cfg_data,
  sbt_in_if                 src,
  sbt_out_if                tokens,
  output int                mismatches,
  output int                outstanding,
  output int                checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    result_t body;
    logic    last;
  } token_rec_t;

  token_rec_t         expected_tokens[$];
  mode_t              scan_mode    = MODE_IDLE;
  logic [LINE_W-1:0]  start_line   = START_LINE_RESET;
  logic [LINE_W-1:0]  line_count   = START_LINE_RESET;
  logic [LINE_W-1:0]  token_line   = '0;
  logic [VALUE_W-1:0] number_acc   = '0;
  logic               digits_ended = 1'b0;
  int                 produced;

  function automatic logic is_blank(logic [BYTE_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_letter(logic [BYTE_W-1:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
  endfunction

  function automatic logic is_digit(logic [BYTE_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic ends_word(logic [BYTE_W-1:0] c);
    return is_blank(c) || c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN;
  endfunction

  function automatic void expect_token(kind_t kind, logic [BYTE_W-1:0] ch, logic ch_valid,
                                       logic [VALUE_W-1:0] value, logic [LINE_W-1:0] line,
                                       logic done);
    token_rec_t r;
    r.body.kind         = kind;
    r.body.text_byte    = ch;
    r.body.text_valid   = ch_valid;
    r.body.number_value = value;
    r.body.line_number  = line;
    r.body.token_done   = done;
    r.last              = 1'b0;
    expected_tokens.push_back(r);
    produced++;
  endfunction

  // A byte seen with no token open.
  function automatic void start_token(logic [BYTE_W-1:0] c);
    kind_t kind;
    if (is_blank(c)) begin
      if (c == CH_NEWLINE) line_count = line_count + 1'b1;
      return;
    end
    case (c)
      CH_PLUS:   kind = KIND_PLUS;
      CH_LPAREN: kind = KIND_LPAREN;
      CH_RPAREN: kind = KIND_RPAREN;
      CH_SEMI:   kind = KIND_SEMI;
      CH_EQUALS: kind = KIND_EQUALS;
      default:   kind = KIND_EOF;
    endcase
    if (kind != KIND_EOF) begin
      expect_token(kind, '0, 1'b0, '0, line_count, 1'b1);
    end else if (c == CH_QUOTE) begin
      scan_mode  = MODE_STRING;
      token_line = line_count;
    end else if (is_letter(c)) begin
      scan_mode  = MODE_IDENT;
      token_line = line_count;
      expect_token(KIND_IDENT, c, 1'b1, '0, token_line, 1'b0);
    end else if (is_digit(c)) begin
      scan_mode    = MODE_NUMBER;
      token_line   = line_count;
      number_acc   = VALUE_W'(c - CH_ZERO);
      digits_ended = 1'b0;
      expect_token(KIND_NUMBER, c, 1'b1, '0, token_line, 1'b0);
    end else begin
      expect_token(KIND_ERROR, c, 1'b1, '0, line_count, 1'b1);
      scan_mode = MODE_HALTED;
    end
  endfunction

  // Completing result of an open string, ident or number.
  function automatic void close_token();
    case (scan_mode)
      MODE_STRING: expect_token(KIND_STRING, '0, 1'b0, '0, token_line, 1'b1);
      MODE_IDENT:  expect_token(KIND_IDENT, '0, 1'b0, '0, token_line, 1'b1);
      MODE_NUMBER: expect_token(KIND_NUMBER, '0, 1'b0, number_acc, token_line, 1'b1);
      default:     return;
    endcase
    scan_mode = MODE_IDLE;
  endfunction

  function automatic void tokenize_byte(logic [BYTE_W-1:0] c, logic eos);
    logic [63:0] grown;
    produced = 0;
    if (scan_mode == MODE_HALTED) return;
    if (eos) begin
      close_token();
      expect_token(KIND_EOF, '0, 1'b0, '0, line_count, 1'b1);
      scan_mode  = MODE_IDLE;
      line_count = start_line;
    end else if (scan_mode == MODE_STRING) begin
      if (c == CH_QUOTE) close_token();
      else expect_token(KIND_STRING, c, 1'b1, '0, token_line, 1'b0);
    end else if (scan_mode == MODE_IDENT || scan_mode == MODE_NUMBER) begin
      if (ends_word(c)) begin
        close_token();
        start_token(c);
      end else if (scan_mode == MODE_IDENT) begin
        expect_token(KIND_IDENT, c, 1'b1, '0, token_line, 1'b0);
      end else begin
        if (!digits_ended && is_digit(c)) begin
          grown      = 64'(number_acc) * 64'd10 + 64'(c - CH_ZERO);
          number_acc = (grown > 64'(VALUE_MAX)) ? VALUE_MAX : grown[VALUE_W-1:0];
        end else begin
          digits_ended = 1'b1;
        end
        expect_token(KIND_NUMBER, c, 1'b1, '0, token_line, 1'b0);
      end
    end else begin
      start_token(c);
    end
    if (produced > 0) expected_tokens[expected_tokens.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    token_rec_t head;
    if (rst) begin
      start_line   = START_LINE_RESET;
      line_count   = START_LINE_RESET;
      scan_mode    = MODE_IDLE;
      token_line   = '0;
      number_acc   = '0;
      digits_ended = 1'b0;
      expected_tokens.delete();
    end else begin
      if (cfg_write) begin
        start_line = cfg_data;
        line_count = cfg_data;
      end
      if (src.valid && src.ready) tokenize_byte(src.input_byte, src.end_of_source);
      if (tokens.valid && tokens.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token result: kind %0d, text 0x%0h", tokens.token_kind,
                 tokens.text_byte);
          mismatches++;
        end else begin
          head = expected_tokens.pop_front();
          checked++;
          check_field("token_kind", 64'(head.body.kind), 64'(tokens.token_kind));
          check_field("text_byte", 64'(head.body.text_byte), 64'(tokens.text_byte));
          check_field("text_valid", 64'(head.body.text_valid), 64'(tokens.text_valid));
          check_field("number_value", 64'(head.body.number_value), 64'(tokens.number_value));
          check_field("line_number", 64'(head.body.line_number), 64'(tokens.line_number));
          check_field("token_done", 64'(head.body.token_done), 64'(tokens.token_done));
          check_field("last", 64'(head.last), 64'(tokens.last));
        end
      end
    end
    outstanding <= expected_tokens.size();
  end

endmodule

>>> bench/tb_source_byte_tokenizer.sv
// Top of the source byte tokenizer bench: clock, reset, start_line writes and the
// source/token traffic. Depends on sbt_pkg, sbt_ifs, the block and sbt_token_checker.
module tb_source_byte_tokenizer import sbt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Whitespace characters that the package does not name.
  localparam logic [BYTE_W-1:0] CH_VTAB = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FEED = 8'h0C;

  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_REQUESTS = 125;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_write = 1'b0;
  logic [LINE_W-1:0] cfg_data  = '0;

  int mismatches;
  int outstanding;
  int checked;

  sbt_in_if  src_ch ();
  sbt_out_if tok_ch ();

  source_byte_tokenizer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .src       (src_ch),
    .tokens    (tok_ch)
  );

  sbt_token_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .src         (src_ch),
    .tokens      (tok_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always #5 clk = ~clk;

  // Source requests waiting to be sent: one byte, or an end-of-source marker.
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              eos;
  } src_req_t;

  src_req_t src_reqs[$];
  int       sent_reqs;
  int       line_writes;

  function automatic void push_byte(logic [BYTE_W-1:0] c);
    src_reqs.push_back('{ch: c, eos: 1'b0});
  endfunction

  // The byte lane is don't-care on an end marker, so it carries noise.
  function automatic void push_eos();
    src_reqs.push_back('{ch: BYTE_W'($urandom_range(0, 255)), eos: 1'b1});
  endfunction

  function automatic logic breaks_word(logic [BYTE_W-1:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_SEMI ||
           c == CH_LPAREN || c == CH_RPAREN;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return CH_LOWER_A + BYTE_W'($urandom_range(0, 25));
    return CH_UPPER_A + BYTE_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [BYTE_W-1:0] rand_digit();
    return CH_ZERO + BYTE_W'($urandom_range(0, 9));
  endfunction

  // Anything that keeps an ident or number open: mostly alnum, sometimes raw bytes
  // (zero, quote, plus, equals, high half) that just stream out as text.
  function automatic logic [BYTE_W-1:0] word_char();
    logic [BYTE_W-1:0] c;
    case ($urandom_range(0, 3))
      0:       c = rand_digit();
      1:       c = rand_letter();
      2: begin
        do c = BYTE_W'($urandom_range(0, 255)); while (breaks_word(c));
      end
      default: c = rand_letter();
    endcase
    return c;
  endfunction

  // Newlines weighted up so line counting (and its wrap) gets exercised.
  function automatic void push_blank();
    case ($urandom_range(0, 7))
      0, 1, 2: push_byte(CH_NEWLINE);
      3:       push_byte(CH_SPACE);
      4:       push_byte(CH_TAB);
      5:       push_byte(CH_VTAB);
      6:       push_byte(CH_FEED);
      default: push_byte(CH_CR);
    endcase
  endfunction

  function automatic void push_punct();
    case ($urandom_range(0, 4))
      0:       push_byte(CH_PLUS);
      1:       push_byte(CH_LPAREN);
      2:       push_byte(CH_RPAREN);
      3:       push_byte(CH_SEMI);
      default: push_byte(CH_EQUALS);
    endcase
  endfunction

  // Ident or number, closed by a delimiter or, now and then, cut off by end of source.
  // Long numbers run past 31 bits to hit saturation; a stray non-digit freezes the value.
  function automatic void push_word(logic numeric);
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 5);
    push_byte(numeric ? rand_digit() : rand_letter());
    repeat (len) begin
      if (numeric && $urandom_range(0, 15) != 0) push_byte(rand_digit());
      else push_byte(word_char());
    end
    case ($urandom_range(0, 9))
      0:       push_eos();
      1:       push_byte(CH_SEMI);
      2:       push_byte(CH_LPAREN);
      3:       push_byte(CH_RPAREN);
      default: push_blank();
    endcase
  endfunction

  // Quoted text with any byte but a quote inside; sometimes left open until end of source.
  function automatic void push_string();
    logic [BYTE_W-1:0] c;
    push_byte(CH_QUOTE);
    repeat ($urandom_range(0, 8)) begin
      do c = BYTE_W'($urandom_range(0, 255)); while (c == CH_QUOTE);
      push_byte(c);
    end
    if ($urandom_range(0, 9) == 0) push_eos();
    else push_byte(CH_QUOTE);
  endfunction

  // Every random chunk starts and ends with the scanner idle, so no error byte
  // is ever produced by accident.
  function automatic void push_random_chunk();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      push_word(1'b0);
    else if (pick < 50) push_word(1'b1);
    else if (pick < 65) push_string();
    else if (pick < 85) push_punct();
    else if (pick < 97) push_blank();
    else                push_eos();
  endfunction

  // Sender: bursts of random length separated by random gaps; about a quarter of
  // the bursts follow the previous one back to back.
  task automatic send_requests();
    src_req_t req;
    int       burst;
    int       gap;
    burst = 0;
    while (src_reqs.size() > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          @(negedge clk);
          src_ch.valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      req = src_reqs.pop_front();
      @(negedge clk);
      src_ch.valid         <= 1'b1;
      src_ch.input_byte    <= req.ch;
      src_ch.end_of_source <= req.eos;
      do @(posedge clk); while (!src_ch.ready);
      burst--;
      sent_reqs++;
    end
    @(negedge clk);
    src_ch.valid <= 1'b0;
  endtask

  // Whitespace and opening quotes leave nothing to wait for, so a few extra
  // cycles follow the last expected token before the block counts as idle.
  task automatic wait_drained();
    int spin;
    spin = 0;
    while (outstanding != 0 && spin < 50000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_start_line(logic [LINE_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    line_writes++;
  endtask

  // Receiver: a 16-bit ready pattern rotated every cycle and reloaded now and then
  // with one of four densities, from always ready to mostly stalled.
  initial begin
    logic [15:0] pattern;
    int          left;
    tok_ch.ready = 1'b0;
    pattern      = '1;
    left         = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       pattern = '1;
          1:       pattern = 16'($urandom);
          2:       pattern = 16'($urandom | $urandom);
          default: pattern = 16'($urandom & $urandom) | 16'h0001;
        endcase
      end
      tok_ch.ready <= pattern[0];
      pattern = {pattern[0], pattern[15:1]};
      left--;
    end
  end

  initial begin
    logic [LINE_W-1:0] line_settings[RANDOM_PHASES];
    logic [BYTE_W-1:0] bad;
    src_ch.valid         = 1'b0;
    src_ch.input_byte    = '0;
    src_ch.end_of_source = 1'b0;
    sent_reqs            = 0;
    line_writes          = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, at the reset start line of 1.
    // Every punctuation token.
    push_byte(CH_PLUS); push_byte(CH_LPAREN); push_byte(CH_RPAREN);
    push_byte(CH_SEMI); push_byte(CH_EQUALS);
    // Empty string: only the completing result.
    push_byte(CH_QUOTE); push_byte(CH_QUOTE);
    // String holding a top byte, a newline (no line count) and a zero byte.
    push_byte(CH_QUOTE); push_byte(8'hFF); push_byte(CH_NEWLINE); push_byte(8'h00);
    push_byte(CH_QUOTE);
    // Ident with a zero byte inside, closed by a newline that counts after it.
    push_byte(CH_LOWER_A); push_byte(8'h00); push_byte(CH_NEWLINE);
    // Number frozen by a non-digit, then closed by a paren: two results in one request.
    push_byte(CH_NINE); push_byte(CH_LOWER_Z); push_byte(CH_ZERO + 8'd5);
    push_byte(CH_RPAREN);
    // Number still open at end of source: completed before the eof token.
    push_byte(CH_ZERO + 8'd7); push_eos();
    send_requests();
    wait_drained();

    // Random part: zero, the top value (newlines wrap the count), random values and
    // one just below the top.
    line_settings[0] = '0;
    line_settings[1] = '1;
    line_settings[2] = LINE_W'($urandom);
    line_settings[3] = LINE_W'(24'hFFFFFE);
    line_settings[4] = LINE_W'($urandom_range(0, 1000));
    foreach (line_settings[p]) begin
      write_start_line(line_settings[p]);
      while (src_reqs.size() < PHASE_REQUESTS) push_random_chunk();
      push_eos();
      send_requests();
      wait_drained();
    end

    // Last: an invalid byte placed after valid tokens halts the block; what follows, end marker
    // included, must produce nothing. Reset is not repeated, so this stays last.
    push_byte(CH_LOWER_A + 8'd23); push_byte(CH_SPACE); push_byte(CH_EQUALS);
    push_byte(CH_ZERO + 8'd1); push_byte(CH_SEMI);
    do bad = BYTE_W'($urandom_range(0, 255));
    while (breaks_word(bad) || bad == CH_PLUS || bad == CH_EQUALS || bad == CH_QUOTE ||
           (bad >= CH_ZERO && bad <= CH_NINE) ||
           (bad >= CH_LOWER_A && bad <= CH_LOWER_Z) ||
           (bad >= CH_UPPER_A && bad <= CH_UPPER_Z));
    push_byte(bad);
    push_byte(CH_PLUS); push_byte(rand_letter()); push_byte(BYTE_W'($urandom_range(0, 255)));
    push_eos();
    send_requests();
    wait_drained();

    if (outstanding != 0) $error("%0d expected token results never arrived", outstanding);
    $display("Coverage: %0d source requests (directed, %0d start_line settings, line wrap,",
             sent_reqs, line_writes);
    $display("  halt on a bad byte); %0d token results compared.", checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("Timeout: token traffic stopped before the end of stimulus");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> source_byte_tokenizer.f
rtl/sbt_pkg.sv
rtl/sbt_ifs.sv
rtl/sbt_front.sv
rtl/sbt_queue.sv
rtl/sbt_back.sv
rtl/source_byte_tokenizer.sv
bench/sbt_token_checker.sv
bench/tb_source_byte_tokenizer.sv
